// ===== sv/msl_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// msl_pkg - shared types and constants of the mecanum slew limited mixer
// CORDIC angle table, gain constants, register indexes and state codes.
// ============================================================================
package msl_pkg;

    localparam int CORDIC_STEPS = 16;

    // gain correction in Q30 and 1/sqrt2 in Q16, consumed one bit per cycle
    localparam logic [29:0] GAIN_K = 30'd652032874;
    localparam logic [29:0] DIAG_K = 30'd46341;

    localparam logic [7:0] REG_TRANS_LIMIT = 8'd0;
    localparam logic [7:0] REG_ROT_LIMIT   = 8'd1;

    typedef enum logic [1:0] {
        PH_TGT,
        PH_VEC,
        PH_STEP
    } msl_phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ITER,
        ST_MX,
        ST_WX,
        ST_MY,
        ST_WY,
        ST_UPDATE,
        ST_DP,
        ST_WDP,
        ST_DM,
        ST_WDM,
        ST_FIN
    } msl_state_t;

    typedef struct packed {
        logic start;
        logic sel_diag;
    } msl_mul_req_t;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        begin
            case (idx)
                5'd0:  v = 32'd536870912;
                5'd1:  v = 32'd316933406;
                5'd2:  v = 32'd167458907;
                5'd3:  v = 32'd85004756;
                5'd4:  v = 32'd42667331;
                5'd5:  v = 32'd21354465;
                5'd6:  v = 32'd10679838;
                5'd7:  v = 32'd5340245;
                5'd8:  v = 32'd2670163;
                5'd9:  v = 32'd1335087;
                5'd10: v = 32'd667544;
                5'd11: v = 32'd333772;
                5'd12: v = 32'd166886;
                5'd13: v = 32'd83443;
                5'd14: v = 32'd41722;
                5'd15: v = 32'd20861;
                5'd16: v = 32'd10430;
                5'd17: v = 32'd5215;
                5'd18: v = 32'd2608;
                5'd19: v = 32'd1304;
                5'd20: v = 32'd652;
                5'd21: v = 32'd326;
                5'd22: v = 32'd163;
                5'd23: v = 32'd81;
                default: v = 32'd0;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// ===== sv/msl_mul.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// msl_mul - bit-serial constant multiplier with rounding
// Multiplies a signed operand by the gain or the diagonal constant, one
// constant bit per cycle, then rounds half away from zero.
// ============================================================================
module msl_mul (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire msl_pkg::msl_mul_req_t  req,
    input  wire logic signed [31:0]     operand,
    output logic                        done,
    output logic signed [31:0]          result
);
    import msl_pkg::*;

    logic        run_reg, run_next;
    logic        done_reg, done_next;
    logic        sel_reg, sel_next;
    logic        neg_reg, neg_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [61:0] a_reg, a_next;
    logic [61:0] acc_reg, acc_next;
    logic [31:0] op_mag;
    logic        kbit;
    logic [4:0]  last;
    logic [61:0] rnd;
    logic [61:0] shifted;

    assign op_mag = operand[31] ? 32'(-operand) : 32'(operand);
    assign kbit   = sel_reg ? DIAG_K[cnt_reg] : GAIN_K[cnt_reg];
    assign last   = sel_reg ? 5'd15 : 5'd29;

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        sel_next  = sel_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        a_next    = a_reg;
        acc_next  = acc_reg;
        if (req.start)
        begin
            run_next = 1'b1;
            sel_next = req.sel_diag;
            neg_next = operand[31];
            cnt_next = 5'd0;
            a_next   = {30'b0, op_mag};
            acc_next = '0;
        end
        else if (run_reg)
        begin
            if (kbit)
                acc_next = acc_reg + a_reg;
            a_next   = {a_reg[60:0], 1'b0};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == last)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sel_reg <= sel_next;
        neg_reg <= neg_next;
        cnt_reg <= cnt_next;
        a_reg   <= a_next;
        acc_reg <= acc_next;
    end

    assign rnd     = acc_reg + (sel_reg ? (62'd1 << 15) : (62'd1 << 37));
    assign shifted = sel_reg ? (rnd >> 16) : (rnd >> 38);
    assign done    = done_reg;
    assign result  = neg_reg ? $signed(-shifted[31:0]) : $signed(shifted[31:0]);

endmodule
`default_nettype wire

// ===== sv/mecanum_slew_limited_mixer.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// mecanum_slew_limited_mixer - slew limited mecanum wheel mixer
// CORDIC target and error vectoring, slew limit, four saturated wheel speeds.
// ============================================================================
//  channel   dir  width  content
//  s_axis    in   48     turn_target, move_speed, move_heading
//  m_axis    out  72     four wheel speeds, 18 bits each
//  cfg       in   16     step limits, written by index
//
//  An item takes 16 CORDIC iterations per pass, two passes or three when the
//  slew limit cuts in, serial gain multiplies of the rotated components and of
//  the error magnitude, and two serial diagonal multiplies; the next request is
//  taken only once the result has loaded.
//  Reset clears the applied state and loads limits 60 and 12.
//  A result waits in the output register; the last step stalls while it is full.
module mecanum_slew_limited_mixer (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [47:0] s_tdata,   // turn_target, move_speed, move_heading
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [71:0] m_tdata,   // front_left, front_right, back_left, back_right
    input  wire         cfg_we,
    input  wire  [7:0]  cfg_index,
    input  wire  [15:0] cfg_data
);
    import msl_pkg::*;

    msl_state_t state_reg, state_next;
    msl_phase_t phase_reg, phase_next;
    logic [4:0]         i_reg, i_next;
    logic signed [31:0] x_reg, x_next, y_reg, y_next;
    logic signed [33:0] z_reg, z_next;
    logic signed [15:0] turn_tgt_reg, turn_tgt_next;
    logic signed [19:0] tx_reg, tx_next, ex_reg, ex_next, ey_reg, ey_next;
    logic signed [19:0] dx_reg, dx_next, dy_reg, dy_next;
    logic signed [19:0] sp_reg, sp_next;
    logic signed [19:0] sm_reg, sm_next;
    logic signed [16:0] ax_reg, ax_next, ay_reg, ay_next, at_reg, at_next;
    logic [15:0]        tlim_reg, rlim_reg;
    logic               ov_reg, ov_next;
    logic [71:0]        od_reg, od_next;

    msl_mul_req_t       mreq;
    logic signed [31:0] mop;
    logic               mdone;
    logic signed [31:0] mres;

    logic signed [31:0] rlen, rx0;
    logic [31:0]        rang, rang2;
    logic               rflip;
    logic signed [31:0] ys, xs;
    logic               sigma;
    logic signed [33:0] atz;
    logic signed [19:0] exc, eyc;
    logic signed [31:0] vx0, vy0;
    logic signed [20:0] sx, sy;
    logic signed [17:0] er, rl18;
    logic signed [17:0] tsum;
    logic signed [17:0] spsum, smsum;
    logic signed [19:0] wfl, wfr, wbl, wbr;

    function automatic logic [17:0] sat18(input logic signed [19:0] v);
        begin
            if (v < -20'sd131072)
                return 18'h20000;
            else if (v > 20'sd131071)
                return 18'h1FFFF;
            else
                return v[17:0];
        end
    endfunction

    function automatic logic signed [16:0] sat17(input logic signed [20:0] v);
        begin
            if (v < -21'sd65536)
                return -17'sd65536;
            else if (v > 21'sd65535)
                return 17'sd65535;
            else
                return v[16:0];
        end
    endfunction

    msl_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mreq),
        .operand (mop),
        .done    (mdone),
        .result  (mres)
    );

    // rotation start: speed at the input heading, or the limit at the error angle
    assign rlen  = (state_reg == ST_IDLE) ? {{8{s_tdata[31]}}, s_tdata[31:16], 8'b0}
                                          : {8'b0, tlim_reg, 8'b0};
    assign rang  = (state_reg == ST_IDLE) ? {s_tdata[47:32], 16'b0} : z_reg[31:0];
    assign rflip = (rang[31:30] == 2'd1) || (rang[31:30] == 2'd2);
    assign rx0   = rflip ? 32'(-rlen) : rlen;
    assign rang2 = rflip ? rang + 32'h8000_0000 : rang;

    assign ys    = y_reg >>> i_reg;
    assign xs    = x_reg >>> i_reg;
    assign sigma = (phase_reg == PH_VEC) ? y_reg[31] : !z_reg[33];
    assign atz   = $signed({2'b00, atan_lut(i_reg)});

    assign exc   = tx_reg - {{3{ax_reg[16]}}, ax_reg};
    assign eyc   = mres[19:0] - {{3{ay_reg[16]}}, ay_reg};
    assign vx0   = {{4{exc[19]}}, exc, 8'b0};
    assign vy0   = {{4{eyc[19]}}, eyc, 8'b0};

    assign sx    = {ax_reg[16], ax_reg[16], ax_reg[16], ax_reg[16], ax_reg}
                 + {dx_reg[19], dx_reg};
    assign sy    = {ay_reg[16], ay_reg[16], ay_reg[16], ay_reg[16], ay_reg}
                 + {dy_reg[19], dy_reg};
    assign er    = {{2{turn_tgt_reg[15]}}, turn_tgt_reg} - {at_reg[16], at_reg};
    assign rl18  = $signed({2'b00, rlim_reg});
    assign tsum  = {at_reg[16], at_reg}
                 + ((er > rl18) ? rl18 : ((er < -rl18) ? -rl18 : er));

    assign spsum = {ay_reg[16], ay_reg} + {ax_reg[16], ax_reg};
    assign smsum = {ay_reg[16], ay_reg} - {ax_reg[16], ax_reg};

    assign wfl = sp_reg + {{3{at_reg[16]}}, at_reg};
    assign wbr = sp_reg - {{3{at_reg[16]}}, at_reg};
    assign wbl = sm_reg + {{3{at_reg[16]}}, at_reg};
    assign wfr = sm_reg - {{3{at_reg[16]}}, at_reg};

    always_comb
    begin
        mreq.start    = 1'b0;
        mreq.sel_diag = 1'b0;
        mop           = x_reg;
        unique case (state_reg)
            ST_MX: mreq.start = 1'b1;
            ST_MY:
            begin
                mreq.start = 1'b1;
                mop        = y_reg;
            end
            ST_DP:
            begin
                mreq.start    = 1'b1;
                mreq.sel_diag = 1'b1;
                mop           = {{14{spsum[17]}}, spsum};
            end
            ST_DM:
            begin
                mreq.start    = 1'b1;
                mreq.sel_diag = 1'b1;
                mop           = {{14{smsum[17]}}, smsum};
            end
            default: ;
        endcase
    end

    always_comb
    begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        i_next        = i_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        turn_tgt_next = turn_tgt_reg;
        tx_next       = tx_reg;
        ex_next       = ex_reg;
        ey_next       = ey_reg;
        dx_next       = dx_reg;
        dy_next       = dy_reg;
        sp_next       = sp_reg;
        sm_next       = sm_reg;
        ax_next       = ax_reg;
        ay_next       = ay_reg;
        at_next       = at_reg;
        ov_next       = ov_reg && !m_tready;
        od_next       = od_reg;
        s_tready      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    turn_tgt_next = s_tdata[15:0];
                    x_next        = rx0;
                    y_next        = '0;
                    z_next        = {{2{rang2[31]}}, rang2};
                    i_next        = '0;
                    phase_next    = PH_TGT;
                    state_next    = ST_ITER;
                end
            end
            ST_ITER:
            begin
                if (sigma)
                begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - atz;
                end
                else
                begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + atz;
                end
                i_next = i_reg + 5'd1;
                if (i_reg == 5'(CORDIC_STEPS - 1))
                    state_next = ST_MX;
            end
            ST_MX:
                state_next = ST_WX;
            ST_WX:
            begin
                if (mdone)
                begin
                    if (phase_reg == PH_VEC)
                    begin
                        if (mres <= $signed({16'b0, tlim_reg}))
                        begin
                            dx_next    = ex_reg;
                            dy_next    = ey_reg;
                            state_next = ST_UPDATE;
                        end
                        else
                        begin
                            x_next     = rx0;
                            y_next     = '0;
                            z_next     = {{2{rang2[31]}}, rang2};
                            i_next     = '0;
                            phase_next = PH_STEP;
                            state_next = ST_ITER;
                        end
                    end
                    else
                    begin
                        if (phase_reg == PH_TGT)
                            tx_next = mres[19:0];
                        else
                            dx_next = mres[19:0];
                        state_next = ST_MY;
                    end
                end
            end
            ST_MY:
                state_next = ST_WY;
            ST_WY:
            begin
                if (mdone)
                begin
                    if (phase_reg == PH_TGT)
                    begin
                        ex_next = exc;
                        ey_next = eyc;
                        // fold the left half plane onto the right
                        if (exc[19])
                        begin
                            x_next = 32'(-vx0);
                            y_next = 32'(-vy0);
                            z_next = 34'sh0_8000_0000;
                        end
                        else
                        begin
                            x_next = vx0;
                            y_next = vy0;
                            z_next = '0;
                        end
                        i_next     = '0;
                        phase_next = PH_VEC;
                        state_next = ST_ITER;
                    end
                    else
                    begin
                        dy_next    = mres[19:0];
                        state_next = ST_UPDATE;
                    end
                end
            end
            ST_UPDATE:
            begin
                ax_next    = sat17(sx);
                ay_next    = sat17(sy);
                at_next    = sat17({{3{tsum[17]}}, tsum});
                state_next = ST_DP;
            end
            ST_DP:
                state_next = ST_WDP;
            ST_WDP:
            begin
                if (mdone)
                begin
                    sp_next    = mres[19:0];
                    state_next = ST_DM;
                end
            end
            ST_DM:
                state_next = ST_WDM;
            ST_WDM:
            begin
                if (mdone)
                begin
                    sm_next    = mres[19:0];
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                // hold until the output register frees up
                if (!ov_reg || m_tready)
                begin
                    od_next    = {sat18(wbr), sat18(wbl), sat18(wfr), sat18(wfl)};
                    ov_next    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            phase_reg <= PH_TGT;
            ax_reg    <= '0;
            ay_reg    <= '0;
            at_reg    <= '0;
            ov_reg    <= 1'b0;
            tlim_reg  <= 16'd60;
            rlim_reg  <= 16'd12;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            ax_reg    <= ax_next;
            ay_reg    <= ay_next;
            at_reg    <= at_next;
            ov_reg    <= ov_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_TRANS_LIMIT: tlim_reg <= cfg_data;
                    REG_ROT_LIMIT:   rlim_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg        <= i_next;
        x_reg        <= x_next;
        y_reg        <= y_next;
        z_reg        <= z_next;
        turn_tgt_reg <= turn_tgt_next;
        tx_reg       <= tx_next;
        ex_reg       <= ex_next;
        ey_reg       <= ey_next;
        dx_reg       <= dx_next;
        dy_reg       <= dy_next;
        sp_reg       <= sp_next;
        sm_reg       <= sm_next;
        od_reg       <= od_next;
    end

    assign m_tvalid = ov_reg;
    assign m_tdata  = od_reg;

endmodule
`default_nettype wire

// ===== sv/msl_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// msl_checker - port level checks of the mecanum slew limited mixer
// Watches the stream ports over time and flags handshake and flow slips.
// ============================================================================
module msl_checker (
    input wire        clk,
    input wire        rst_n,
    input wire        s_tvalid,
    input wire        s_tready,
    input wire        m_tvalid,
    input wire        m_tready,
    input wire [71:0] m_tdata
);
    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one request at a time: busy right after an accepted request
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while busy");

    // no result appears in the cycle after a request is taken
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result too early");

    a_rst: assert property (@(posedge clk) !rst_n |-> !m_tvalid)
        else $error("result valid in reset");

endmodule

bind mecanum_slew_limited_mixer msl_checker u_msl_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
